// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

`endif

// ===== rtl/lwps_pkg.sv =====
// ----------------------------------------------------------------------------
// lwps_pkg
// Types and constants shared by the LCD window pixel streamer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwps_pkg;

   // Display command codes
   localparam logic [7:0] CMD_COLUMN   = 8'h2a;
   localparam logic [7:0] CMD_ROW      = 8'h2b;
   localparam logic [7:0] CMD_MEMWRITE = 8'h2c;

   localparam logic [7:0] OFFSET_RESET = 8'd35;

   // Item kinds carried on req_tuser
   localparam logic MODE_REGION = 1'b0;
   localparam logic MODE_PIXEL  = 1'b1;

   localparam int XY_BITS    = 10;
   localparam int SIZE_BITS  = 11;
   localparam int PIXEL_BITS = 32;
   localparam int ADDR_BITS  = 16;
   localparam int COUNT_BITS = 21;
   localparam int PROD_BITS  = 2 * SIZE_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Byte positions within a region run
   localparam logic [3:0] BYTE_COL_CMD   = 4'd0;
   localparam logic [3:0] BYTE_XS_HI     = 4'd1;
   localparam logic [3:0] BYTE_XS_LO     = 4'd2;
   localparam logic [3:0] BYTE_XE_HI     = 4'd3;
   localparam logic [3:0] BYTE_XE_LO     = 4'd4;
   localparam logic [3:0] BYTE_ROW_CMD   = 4'd5;
   localparam logic [3:0] BYTE_YS_HI     = 4'd6;
   localparam logic [3:0] BYTE_YS_LO     = 4'd7;
   localparam logic [3:0] BYTE_YE_HI     = 4'd8;
   localparam logic [3:0] BYTE_YE_LO     = 4'd9;
   localparam logic [3:0] BYTE_WRITE_CMD = 4'd10;

   // Byte positions within a pixel run
   localparam logic [3:0] BYTE_PIX_HI = 4'd0;
   localparam logic [3:0] BYTE_PIX_LO = 4'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // One classified item waiting for the back end
   typedef struct packed {
      logic                  is_pixel;
      logic [ADDR_BITS-1:0]  xs;
      logic [ADDR_BITS-1:0]  xe;
      logic [ADDR_BITS-1:0]  ys;
      logic [ADDR_BITS-1:0]  ye;
      logic [COUNT_BITS-1:0] count;
      logic [15:0]           rgb565;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/lwps_front.sv =====
// ----------------------------------------------------------------------------
// lwps_front
// Accepts items, holds the column offset and works out addresses, pixel
// count and RGB565 value for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwps_front
   import lwps_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [79:0]                req_tdata,
   input  logic                       req_tuser,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_data,
   input  queue_status_type           q_status,
   output logic                       push,
   output job_type                    push_job
);

   localparam logic [XY_BITS-1:0] XY_MASK =
      (COORD_BITS >= XY_BITS) ? {XY_BITS{1'b1}} : XY_BITS'((1 << COORD_BITS) - 1);

   logic [7:0]            offset_ff;
   logic [7:0]            offset_in;

   logic [XY_BITS-1:0]    region_x;
   logic [XY_BITS-1:0]    region_y;
   logic [SIZE_BITS-1:0]  region_width;
   logic [SIZE_BITS-1:0]  region_height;
   logic [PIXEL_BITS-1:0] pixel_xrgb;
   logic [PROD_BITS-1:0]  prod;
   logic [ADDR_BITS-1:0]  xs;

   assign region_x      = req_tdata[9:0] & XY_MASK;
   assign region_y      = req_tdata[19:10] & XY_MASK;
   assign region_width  = req_tdata[30:20];
   assign region_height = req_tdata[41:31];
   assign pixel_xrgb    = req_tdata[73:42];

   assign csr_ready  = 1'b1;
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   assign offset_in = (csr_valid && csr_ready) ? csr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   assign prod = PROD_BITS'(region_width) * PROD_BITS'(region_height);
   assign xs   = ADDR_BITS'(region_x) + ADDR_BITS'(offset_ff);

   always_comb begin
      push_job.is_pixel = (req_tuser == MODE_PIXEL);
      push_job.xs       = xs;
      push_job.xe       = xs + ADDR_BITS'(region_width) - ADDR_BITS'(1);
      push_job.ys       = ADDR_BITS'(region_y);
      push_job.ye       = ADDR_BITS'(region_y) + ADDR_BITS'(region_height) - ADDR_BITS'(1);
      // clamp oversized regions
      push_job.count    = (prod > PROD_BITS'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_BITS-1:0];
      push_job.rgb565   = {pixel_xrgb[23:19], pixel_xrgb[15:10], pixel_xrgb[7:3]};
   end

endmodule

// ===== rtl/lwps_queue.sv =====
// ----------------------------------------------------------------------------
// lwps_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwps_queue
   import lwps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;

   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/lwps_back.sv =====
// ----------------------------------------------------------------------------
// lwps_back
// Steps through the bytes of the item at the queue head, keeps the
// remaining-pixel count and drives the registered byte output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwps_back
   import lwps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser
);

   logic [3:0]            idx_ff;
   logic [3:0]            idx_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [7:0]            byte_ff;
   logic [7:0]            byte_in;
   logic                  cmd_ff;
   logic                  cmd_in;
   logic                  last_ff;
   logic                  last_in;
   logic                  done_ff;
   logic                  done_in;
   logic                  emit;

   assign emit = !q_status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      byte_in  = byte_ff;
      cmd_in   = 1'b0;
      last_in  = 1'b0;
      done_in  = 1'b0;
      count_in = count_ff;
      if (head_job.is_pixel) begin
         last_in = (idx_ff == BYTE_PIX_LO);
         byte_in = last_in ? head_job.rgb565[7:0] : head_job.rgb565[15:8];
         if (emit && last_in && (count_ff != '0)) begin
            count_in = count_ff - COUNT_BITS'(1);
            done_in  = (count_ff == COUNT_BITS'(1));
         end
      end else begin
         unique case (idx_ff)
            BYTE_COL_CMD: begin
               byte_in = CMD_COLUMN;
               cmd_in  = 1'b1;
            end
            BYTE_XS_HI:   byte_in = head_job.xs[15:8];
            BYTE_XS_LO:   byte_in = head_job.xs[7:0];
            BYTE_XE_HI:   byte_in = head_job.xe[15:8];
            BYTE_XE_LO:   byte_in = head_job.xe[7:0];
            BYTE_ROW_CMD: begin
               byte_in = CMD_ROW;
               cmd_in  = 1'b1;
            end
            BYTE_YS_HI:   byte_in = head_job.ys[15:8];
            BYTE_YS_LO:   byte_in = head_job.ys[7:0];
            BYTE_YE_HI:   byte_in = head_job.ye[15:8];
            BYTE_YE_LO:   byte_in = head_job.ye[7:0];
            default: begin
               byte_in = CMD_MEMWRITE;
               cmd_in  = 1'b1;
               last_in = 1'b1;
            end
         endcase
         // reload; pending pixels of an earlier region are dropped
         if (emit && last_in) begin
            count_in = head_job.count;
         end
      end
      pop      = emit && last_in;
      idx_in   = emit ? (last_in ? '0 : idx_ff + 4'd1) : idx_ff;
      valid_in = emit || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // hold the payload while the output stalls
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         cmd_ff  <= cmd_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {done_ff, cmd_ff};

endmodule

// ===== rtl/lcd_window_pixel_streamer.sv =====
// The first byte of an item goes from its queue entry into the byte output register, then shows on rsp_tvalid.
// One output byte per cycle while the queue holds an item and rsp_tready is high; a pixel item is 2 bytes, a region 11.
// The single byte output register is the bottleneck; a two-entry queue decouples input.
// Reset (synchronous, active high) empties the queue, clears the pixel count and
// output valid, and sets column_offset to 35.
// ----------------------------------------------------------------------------
// lcd_window_pixel_streamer
// Formats window address commands and RGB565 pixel bytes for a display panel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd_window_pixel_streamer
   import lwps_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // region_x[9:0], region_y[19:10], region_width[30:20], region_height[41:31],
   // pixel_xrgb[73:42], zero fill [79:74]
   input  logic [79:0] req_tdata,
   // mode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // is_command[0], region_done[1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   lwps_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job)
   );

   lwps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   lwps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `ASSERT_ALWAYS(a_queue_state, clock, reset, !(q_status.full && q_status.empty), "queue full and empty")
   `ASSERT_IMPLIES(a_pop_needs_entry, clock, reset, pop, !q_status.empty, "pop from empty queue")
   `ASSERT_IMPLIES(a_done_on_last_data, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast && !rsp_tuser[0], "region_done off last data byte")
   `ASSERT_IMPLIES(a_cmd_last_is_write, clock, reset, rsp_tvalid && rsp_tuser[0] && rsp_tlast, rsp_tdata == CMD_MEMWRITE, "last command byte not memory write")

endmodule
